### rtl/hipt_pkg.sv
`timescale 1ns / 1ps
package hipt_pkg;
   localparam int Frames = 256;
   localparam int IdxW = 8;
   localparam int FcW = 9;
   localparam int MaxPages = 64;
   localparam int HashShl = 10;
   localparam int HashShr = 6;
   // Entry layout: valid, length, pid, page.
   localparam int EntW = 1 + 2 + 24 + 8;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE_PAGE = 2'd2;
   localparam logic [1:0] ACT_FREE_PROC = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;

   localparam logic CSR_FRAME_COUNT = 1'b0;
   localparam logic CSR_RESERVED = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      logic [23:0] pid_chars;
      logic [1:0] pid_length;
      logic [7:0] page;
      logic [6:0] page_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] frame;
      logic [7:0] assigned_page;
      logic last;
   } rsp_type;
endpackage

### rtl/hipt_if.sv
`timescale 1ns / 1ps
interface hipt_req_if import hipt_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface hipt_rsp_if import hipt_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/hipt_ram.sv
`timescale 1ns / 1ps
module hipt_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/hipt_hash.sv
`timescale 1ns / 1ps
// Home slot: one hash round per cycle, then a product step, then a restoring
// remainder of one bit per cycle and a sign fix-up step.
module hipt_hash import hipt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [23:0] pid,
   input logic [1:0] len,
   input logic [7:0] page,
   input logic [FcW-1:0] fc,
   output logic done,
   output logic [IdxW-1:0] slot
);
   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_MIX = 3'd1;
   localparam logic [2:0] H_MUL = 3'd2;
   localparam logic [2:0] H_DIV = 3'd3;
   localparam logic [2:0] H_FIX = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [31:0] h_ff, h_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [5:0] bit_ff, bit_in;
   logic [FcW:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [IdxW-1:0] slot_ff, slot_in;
   logic [31:0] t, mag;
   logic [FcW:0] shifted;
   logic [FcW:0] r;

   assign done = (state_ff == H_FIX);
   assign slot = slot_in;
   assign mag = ~h_ff + 32'd1;

   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      cnt_in = cnt_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      slot_in = slot_ff;
      t = 32'd0;
      shifted = '0;
      r = '0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in = 32'd0;
               cnt_in = 2'd0;
               state_in = H_MIX;
            end
         end
         H_MIX: begin
            t = h_ff + {24'd0, pid[8*cnt_ff +: 8]};
            t = t + (t << HashShl);
            t = t ^ 32'($signed(t) >>> HashShr);
            h_in = t;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff + 2'd1 >= len) begin
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            if (page != 8'd0) begin
               h_in = h_ff * {24'd0, page};
            end
            state_in = H_DIV;
            bit_in = 6'd31;
            rem_in = '0;
         end
         H_DIV: begin
            if (bit_ff == 6'd31) begin
               neg_in = h_ff[31];
               if (h_ff[31]) begin
                  h_in = mag;
               end
            end
            shifted = {rem_ff[FcW-1:0], (bit_ff == 6'd31 && h_ff[31]) ?
                       mag[31] : h_ff[bit_ff[4:0]]};
            rem_in = (shifted >= {1'b0, fc}) ? shifted - {1'b0, fc} : shifted;
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               state_in = H_FIX;
            end
         end
         H_FIX: begin
            r = rem_ff;
            if (neg_ff && r != '0) begin
               r = {1'b0, fc} - r;
            end
            slot_in = r[IdxW-1:0];
            state_in = H_IDLE;
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      h_ff <= h_in;
      cnt_ff <= cnt_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      slot_ff <= slot_in;
   end
endmodule

### rtl/hashed_inverted_page_table.sv
`timescale 1ns / 1ps
// Hashing runs one round per ID character, then frames are probed in turn;
// lookup and allocate probe up to fc frames per page, while frees and the
// allocate scan walk the frames in order from the first.
// One item at a time; the next is taken once the last result has transferred.
// Reset: synchronous, runs a clearing pass over all 256 table entries, during
// which no item is accepted; registers return to 256 frames and none reserved.
module hashed_inverted_page_table import hipt_pkg::*; (
   input logic clock,
   input logic reset,
   hipt_req_if.sink req,
   hipt_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [8:0] csr_write_data
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_HASH = 4'd2;
   localparam logic [3:0] S_WAITH = 4'd3;
   localparam logic [3:0] S_RD = 4'd4;
   localparam logic [3:0] S_CHK = 4'd5;
   localparam logic [3:0] S_OUT = 4'd6;
   localparam logic [3:0] S_SCANRD = 4'd7;
   localparam logic [3:0] S_SCANCHK = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [FcW-1:0] fc_reg_ff, fc_reg_in;
   logic [7:0] resv_ff, resv_in;
   logic [1:0] act_ff, act_in;
   logic [23:0] pid_ff, pid_in;
   logic [1:0] len_ff, len_in;
   logic [8:0] page_ff, page_in;
   logic [6:0] left_ff, left_in;
   logic [FcW-1:0] n_ff, n_in;
   logic [FcW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] maxpg_ff, maxpg_in;
   rsp_type out_ff, out_in;
   logic [FcW-1:0] fc;
   logic hstart, hdone;
   logic [IdxW-1:0] hslot;
   logic we;
   logic [IdxW-1:0] waddr;
   logic [EntW-1:0] wdata, rdata;
   logic [IdxW-1:0] raddr;
   logic e_valid, own, usable, pgeq;
   logic [1:0] e_len;
   logic [23:0] e_pid;
   logic [7:0] e_page;
   logic [FcW:0] nxt;
   logic [1:0] len_n;
   logic [23:0] pid_n;

   assign fc = (fc_reg_ff == '0) ? 9'd1 : (fc_reg_ff > 9'(Frames)) ?
               9'(Frames) : fc_reg_ff;
   assign {e_valid, e_len, e_pid, e_page} = rdata;
   assign usable = idx_ff >= {1'b0, resv_ff} && idx_ff < fc;
   assign own = e_valid && e_len == len_ff && e_pid == pid_ff;
   assign pgeq = {1'b0, e_page} == page_ff;
   assign raddr = idx_ff[IdxW-1:0];
   assign nxt = {1'b0, idx_ff} + 10'd1;
   assign len_n = (req.data.pid_length == 2'd0) ? 2'd1 : req.data.pid_length;
   assign pid_n = (len_n == 2'd1) ? {16'd0, req.data.pid_chars[7:0]} :
                  (len_n == 2'd2) ? {8'd0, req.data.pid_chars[15:0]} :
                  req.data.pid_chars;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = out_ff;
   assign hstart = (state_ff == S_HASH);

   hipt_hash u_hash (
      .clock(clock), .reset(reset), .start(hstart), .pid(pid_ff), .len(len_ff),
      .page(page_ff[7:0]), .fc(fc), .done(hdone), .slot(hslot)
   );

   hipt_ram #(.Width(EntW), .Depth(Frames)) u_table (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   always_comb begin
      state_in = state_ff;
      fc_reg_in = fc_reg_ff;
      resv_in = resv_ff;
      act_in = act_ff;
      pid_in = pid_ff;
      len_in = len_ff;
      page_in = page_ff;
      left_in = left_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      first_in = first_ff;
      maxpg_in = maxpg_ff;
      out_in = out_ff;
      we = 1'b0;
      waddr = idx_ff[IdxW-1:0];
      wdata = '0;
      if (csr_write_enable) begin
         if (csr_index == CSR_FRAME_COUNT) begin
            fc_reg_in = csr_write_data;
         end else begin
            resv_in = csr_write_data[7:0];
         end
      end
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            idx_in = idx_ff + 9'd1;
            if (idx_ff == 9'(Frames - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               act_in = req.data.action;
               pid_in = pid_n;
               len_in = len_n;
               page_in = {1'b0, req.data.page};
               left_in = (req.data.page_count == 7'd0) ? 7'd1 :
                         (req.data.page_count > 7'(MaxPages)) ? 7'(MaxPages) :
                         req.data.page_count;
               idx_in = '0;
               found_in = 1'b0;
               maxpg_in = 8'd0;
               if (req.data.action == ACT_LOOKUP) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_SCANRD;
               end
            end
         end
         S_HASH: state_in = S_WAITH;
         S_WAITH: begin
            if (hdone) begin
               idx_in = {1'b0, hslot};
               n_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            if (act_ff == ACT_LOOKUP && usable && own && pgeq) begin
               out_in = '{ST_OK, idx_ff[7:0], page_ff[7:0], 1'b1};
               state_in = S_OUT;
            end else if (act_ff == ACT_ALLOC && usable && !e_valid) begin
               we = 1'b1;
               wdata = {1'b1, len_ff, pid_ff, page_ff[7:0]};
               out_in = '{ST_OK, idx_ff[7:0], page_ff[7:0], left_ff == 7'd1};
               state_in = S_OUT;
            end else if (n_ff + 9'd1 >= fc) begin
               out_in = (act_ff == ACT_LOOKUP) ?
                        '{ST_NOT_FOUND, 8'd0, page_ff[7:0], 1'b1} :
                        '{ST_NO_SPACE, 8'd0, page_ff[7:0], 1'b1};
               state_in = S_OUT;
            end else begin
               n_in = n_ff + 9'd1;
               idx_in = (nxt >= {1'b0, fc}) ? '0 : nxt[FcW-1:0];
               state_in = S_RD;
            end
         end
         S_SCANRD: state_in = S_SCANCHK;
         S_SCANCHK: begin
            idx_in = nxt[FcW-1:0];
            if (usable && own) begin
               if (act_ff == ACT_FREE_PAGE && pgeq) begin
                  we = 1'b1;
                  out_in = '{ST_OK, idx_ff[7:0], page_ff[7:0], 1'b1};
                  state_in = S_OUT;
               end else if (act_ff == ACT_FREE_PROC) begin
                  we = 1'b1;
                  if (!found_ff) begin
                     first_in = idx_ff[7:0];
                  end
                  found_in = 1'b1;
               end else if (act_ff == ACT_ALLOC) begin
                  if (!found_ff || e_page > maxpg_ff) begin
                     maxpg_in = e_page;
                  end
                  found_in = 1'b1;
               end
            end
            if (state_in == S_SCANCHK) begin
               if (nxt >= {1'b0, fc}) begin
                  unique case (act_ff)
                     ACT_FREE_PAGE: begin
                        out_in = '{ST_NOT_FOUND, 8'd0, page_ff[7:0], 1'b1};
                        state_in = S_OUT;
                     end
                     ACT_FREE_PROC: begin
                        out_in = found_in ? '{ST_OK, first_in, 8'd0, 1'b1} :
                                 '{ST_NOT_FOUND, 8'd0, 8'd0, 1'b1};
                        state_in = S_OUT;
                     end
                     default: begin
                        page_in = found_in ? {1'b0, maxpg_in} + 9'd1 : 9'd0;
                        if (found_in && maxpg_in == 8'hFF) begin
                           out_in = '{ST_NO_SPACE, 8'd0, 8'd0, 1'b1};
                           state_in = S_OUT;
                        end else begin
                           state_in = S_HASH;
                        end
                     end
                  endcase
               end else begin
                  state_in = S_SCANRD;
               end
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               if (out_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  left_in = left_ff - 7'd1;
                  page_in = page_ff + 9'd1;
                  if (page_ff == 9'd255) begin
                     out_in = '{ST_NO_SPACE, 8'd0, 8'd0, 1'b1};
                  end else begin
                     state_in = S_HASH;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         fc_reg_ff <= 9'd256;
         resv_ff <= 8'd0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fc_reg_ff <= fc_reg_in;
         resv_ff <= resv_in;
         idx_ff <= idx_in;
      end
      act_ff <= act_in;
      pid_ff <= pid_in;
      len_ff <= len_in;
      page_ff <= page_in;
      left_ff <= left_in;
      n_ff <= n_in;
      found_ff <= found_in;
      first_ff <= first_in;
      maxpg_ff <= maxpg_in;
      out_ff <= out_in;
   end
endmodule
